/* rtl/core/ir_range_average_and_convert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the IR range averaging and conversion block
// Short forms for the clocked checks used in the RTL modules.
// ----------------------------------------------------------------------------
`ifndef IR_RANGE_AVERAGE_AND_CONVERT_MACROS_SVH
`define IR_RANGE_AVERAGE_AND_CONVERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IRRAC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("irrac assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IRRAC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("irrac assertion failed");

`endif

/* rtl/core/irrac_pkg.sv */
// ----------------------------------------------------------------------------
// IR range averaging and conversion package
// Shared widths, constants and the structs that pass between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package irrac_pkg;

	localparam int SAMPLE_W = 10;
	localparam int SUM_W    = 16;
	localparam int DIST_W   = 10;
	localparam int DIV_W    = 16;
	localparam int STEP_W   = 4;
	localparam int FEET_W   = 15;
	localparam int PROD_W   = DIST_W + FEET_W + 1;

	localparam logic [DIV_W-1:0]  BASE_OFFSET = 16'd206;
	localparam logic [DIV_W-1:0]  RANGE_NUMER = 16'd30500;
	localparam logic [DIST_W-1:0] DIST_MIN    = 10'd30;
	localparam logic [DIST_W-1:0] DIST_MAX    = 10'd600;
	// 0.328084 in unsigned Q0.16.
	localparam logic [FEET_W-1:0] FEET_Q16    = 15'd21501;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic              in_feet;
		logic [DIST_W-1:0] shown_distance;
		logic [DIST_W-1:0] distance_cm;
	} result_t;

endpackage

`default_nettype wire

/* rtl/core/ir_range_average_and_convert.sv */
// ----------------------------------------------------------------------------
// IR range averaging and conversion, top level
// Averages groups of converter samples and turns the mean into a distance.
// ----------------------------------------------------------------------------
// Each request on the slave stream carries one 10-bit converter sample. The
// block adds AVERAGE_COUNT samples, divides the sum by AVERAGE_COUNT to form
// the mean and converts it to a distance of floor(30500 / (mean - 206)) cm,
// clamped to 30..600; a mean below 206 gives 30 and a mean of exactly 206
// gives 600. With display_feet set, the shown value is the distance times
// 0.328084 in Q0.16, truncated. One result leaves on the master stream per
// group. A sample that does not close a group is accepted as soon as it is
// offered while no conversion runs. The sample that closes a group starts
// the conversion, and its accepting edge also forms the mean by multiplying
// the sum with a constant reciprocal. The slave side then stays not ready
// while ST_MEAN checks the corner means and starts the divider, the divider
// runs at one quotient bit per cycle, the distance is clamped as it
// finishes, ST_FEET multiplies for the feet value and ST_DONE hands the
// result to the output register. A mean at or below 206 skips the division
// and goes from ST_MEAN straight to ST_FEET. The output register holds a
// finished result while the next group collects; if it is still occupied
// when the following result is ready, the sequencer waits for it to drain
// and the slave side stays not ready meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ir_range_average_and_convert_macros.svh"

module ir_range_average_and_convert #(
	parameter int AVERAGE_COUNT = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration: display_feet register.
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	// Slave stream of samples.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [9:0] sample, [15:10] zero
	// Master stream of results.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [9:0] distance_cm, [19:10] shown_distance
	output logic             m_tuser    // [0] in_feet
);

	localparam int CNT_W = $clog2(AVERAGE_COUNT);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AVERAGE_COUNT - 1);

	logic                        display_feet_q;
	logic [irrac_pkg::SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]            count_q;
	logic                        out_valid_q;
	irrac_pkg::result_t          out_q;

	logic                        accept;
	logic                        group_last;
	logic [irrac_pkg::SUM_W-1:0] sum_nxt;
	logic                        slot_free;
	logic                        conv_busy;
	logic                        conv_valid;
	irrac_pkg::result_t          conv_res;

	// The running sum wraps modulo 2^16, as the averaging register does.
	assign accept     = s_tvalid && s_tready;
	assign group_last = (count_q == CNT_LAST);
	assign sum_nxt    = sum_q + irrac_pkg::SUM_W'(s_tdata[irrac_pkg::SAMPLE_W-1:0]);
	assign slot_free  = !out_valid_q || m_tready;
	assign s_tready   = !conv_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_feet_q <= 1'b0;
			sum_q          <= '0;
			count_q        <= '0;
		end else begin
			if (cfg_we) display_feet_q <= cfg_wdata;
			if (accept) begin
				if (group_last) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= sum_nxt;
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	irrac_conv #(
		.AVERAGE_COUNT (AVERAGE_COUNT)
	) u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && group_last),
		.group_sum (sum_nxt),
		.feet_mode (display_feet_q),
		.slot_free (slot_free),
		.busy      (conv_busy),
		.res_valid (conv_valid),
		.res       (conv_res)
	);

	// Output register: loads a finished result whenever the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (conv_valid && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (conv_valid && slot_free) out_q <= conv_res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_q.shown_distance, out_q.distance_cm};
	assign m_tuser  = out_q.in_feet;

	`IRRAC_ASSERT_SAME(a_cm_range, out_valid_q,
		out_q.distance_cm >= irrac_pkg::DIST_MIN && out_q.distance_cm <= irrac_pkg::DIST_MAX)
	`IRRAC_ASSERT_SAME(a_cm_shown, out_valid_q && !out_q.in_feet,
		out_q.shown_distance == out_q.distance_cm)
	`IRRAC_ASSERT_NEXT(a_group_restart, accept && group_last, count_q == '0 && sum_q == '0)

endmodule

`default_nettype wire

/* rtl/core/irrac_div.sv */
// ----------------------------------------------------------------------------
// IR range divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ir_range_average_and_convert_macros.svh"

module irrac_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire irrac_pkg::div_req_t req,
	output irrac_pkg::div_rsp_t    rsp
);

	logic [irrac_pkg::DIV_W-1:0]  rem_q;
	logic [irrac_pkg::DIV_W-1:0]  quo_q;
	logic [irrac_pkg::DIV_W-1:0]  dvs_q;
	logic [irrac_pkg::STEP_W-1:0] step_q;
	logic                         busy_q;
	logic                         done_q;

	logic [irrac_pkg::DIV_W:0]   shifted;
	logic                        q_bit;
	logic [irrac_pkg::DIV_W-1:0] rem_nxt;

	// Bring down the next dividend bit and try the subtraction.
	always_comb begin
		shifted = {rem_q, quo_q[irrac_pkg::DIV_W-1]};
		q_bit   = (shifted >= {1'b0, dvs_q});
		rem_nxt = q_bit ? irrac_pkg::DIV_W'(shifted - {1'b0, dvs_q})
		                : irrac_pkg::DIV_W'(shifted);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[irrac_pkg::DIV_W-2:0], q_bit};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	`IRRAC_ASSERT_SAME(a_no_restart, req.start, !busy_q)
	`IRRAC_ASSERT_NEXT(a_start_runs, req.start, busy_q && !done_q)
	`IRRAC_ASSERT_NEXT(a_done_pulse, done_q, !done_q && !busy_q)

endmodule

`default_nettype wire

/* rtl/core/irrac_conv.sv */
// ----------------------------------------------------------------------------
// IR range conversion sequencer
// Turns a group sum into a clamped distance: the mean by reciprocal
// multiplication, the distance with the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module irrac_conv #(
	parameter int AVERAGE_COUNT = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [irrac_pkg::SUM_W-1:0] group_sum,
	input  wire logic                        feet_mode,
	input  wire logic                        slot_free,
	output logic                             busy,
	output logic                             res_valid,
	output irrac_pkg::result_t               res
);

	// The mean is floor(sum * MEAN_RECIP / 2^MEAN_SH). MEAN_RECIP is one above
	// floor(2^MEAN_SH / AVERAGE_COUNT), which is exact for every 16-bit sum.
	localparam int MEAN_SH = irrac_pkg::SUM_W + $clog2(AVERAGE_COUNT);
	localparam int RECIP_W = irrac_pkg::SUM_W + 2;
	localparam int MPROD_W = MEAN_SH + irrac_pkg::SUM_W + 2;
	localparam logic [RECIP_W-1:0] MEAN_RECIP =
		RECIP_W'(((64'd1 << MEAN_SH) / 64'(AVERAGE_COUNT)) + 64'd1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MEAN  = 5'b00010,
		ST_RANGE = 5'b00100,
		ST_FEET  = 5'b01000,
		ST_DONE  = 5'b10000
	} conv_state_t;

	conv_state_t state_q;

	logic [irrac_pkg::DIST_W-1:0] cm_q;
	logic [irrac_pkg::PROD_W-1:0] prod_q;
	logic                         feet_q;
	logic [irrac_pkg::DIV_W-1:0]  mean_q;

	irrac_pkg::div_req_t div_req;
	irrac_pkg::div_rsp_t div_rsp;

	logic [MPROD_W-1:0]          mean_prod;
	logic [irrac_pkg::DIV_W-1:0] quot;
	logic                        mean_low;
	logic                        mean_base;

	irrac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign mean_prod = MPROD_W'(group_sum) * MPROD_W'(MEAN_RECIP);
	assign quot      = div_rsp.quotient;
	assign mean_low  = (mean_q < irrac_pkg::BASE_OFFSET);
	assign mean_base = (mean_q == irrac_pkg::BASE_OFFSET);

	always_comb begin
		div_req.start    = (state_q == ST_MEAN) && !mean_low && !mean_base;
		div_req.dividend = irrac_pkg::RANGE_NUMER;
		div_req.divisor  = mean_q - irrac_pkg::BASE_OFFSET;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_MEAN;
				end
				ST_MEAN: begin
					state_q <= (mean_low || mean_base) ? ST_FEET : ST_RANGE;
				end
				ST_RANGE: begin
					if (div_rsp.done) state_q <= ST_FEET;
				end
				ST_FEET: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			feet_q <= feet_mode;
			mean_q <= mean_prod[MEAN_SH +: irrac_pkg::DIV_W];
		end
		if (state_q == ST_MEAN) begin
			cm_q <= mean_low ? irrac_pkg::DIST_MIN : irrac_pkg::DIST_MAX;
		end
		if (state_q == ST_RANGE && div_rsp.done) begin
			if (quot >= irrac_pkg::DIV_W'(irrac_pkg::DIST_MAX)) begin
				cm_q <= irrac_pkg::DIST_MAX;
			end else if (quot <= irrac_pkg::DIV_W'(irrac_pkg::DIST_MIN)) begin
				cm_q <= irrac_pkg::DIST_MIN;
			end else begin
				cm_q <= irrac_pkg::DIST_W'(quot);
			end
		end
		if (state_q == ST_FEET) begin
			prod_q <= irrac_pkg::PROD_W'(cm_q) * irrac_pkg::PROD_W'(irrac_pkg::FEET_Q16);
		end
	end

	assign busy               = (state_q != ST_IDLE);
	assign res_valid          = (state_q == ST_DONE);
	assign res.distance_cm    = cm_q;
	assign res.in_feet        = feet_q;
	assign res.shown_distance = feet_q ? prod_q[irrac_pkg::PROD_W-1 -: irrac_pkg::DIST_W]
	                                   : cm_q;

endmodule

`default_nettype wire
